// File: rtl/kbsrp_pkg.sv
// ----------------------------------------------------------------------------
// kbsrp_pkg: shared types and constants for the key bit store
// Command and status codes, payload structs, the decode record and the
// word mask helpers used by the range parity walk.
// ----------------------------------------------------------------------------
package kbsrp_pkg;

	localparam int KEY_WORDS_DEF = 256;
	localparam int WORD_BITS     = 64;
	localparam int LEN_W         = 15;

	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic [LEN_W-1:0] KEY_LENGTH_RST = 15'd16384;

	// Command codes.
	localparam logic [2:0] CMD_LOAD   = 3'd0;
	localparam logic [2:0] CMD_READ   = 3'd1;
	localparam logic [2:0] CMD_SET    = 3'd2;
	localparam logic [2:0] CMD_FLIP   = 3'd3;
	localparam logic [2:0] CMD_PARITY = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_REVERSED = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [13:0] bit_index;
		logic [13:0] range_end;
		logic        new_bit;
		logic [7:0]  word_index;
		logic [63:0] word_data;
	} item_t;

	typedef struct packed {
		logic       bit_out;
		logic       parity_out;
		logic [1:0] status;
	} result_t;

	// Outcome of decoding one command against the current key length.
	typedef struct packed {
		logic        immediate;  // result is known at transfer time
		logic        load;       // write load_data to the addressed word
		logic [1:0]  status;
		logic [63:0] load_data;
	} dec_t;

	// Keeps the bits at positions >= pos.
	function automatic logic [63:0] low_mask(input logic [5:0] pos);
		return ALL_ONES << pos;
	endfunction

	// Keeps the bits at positions <= pos.
	function automatic logic [63:0] high_mask(input logic [5:0] pos);
		return ALL_ONES >> (6'd63 - pos);
	endfunction

endpackage

// File: rtl/key_bit_store_range_parity.sv
// ----------------------------------------------------------------------------
// key_bit_store_range_parity: key bit store with range parity
// Holds a secret key in a word-wide synchronous memory and serves load,
// bit read, bit set, bit flip and inclusive range parity commands.
// ----------------------------------------------------------------------------
// The key is kept as 64-bit words in one single-port-write, single-port-read
// memory with registered read data; key bit n lives in word n/64 at position
// n%64. Commands are taken one at a time. A load, an unknown command or any
// command that fails its bounds check finishes in the transfer cycle and its
// result appears in the output register at the next edge. Read, set and flip
// first read the word, then test or modify it and write it back. Range
// parity reads one word per cycle through the memory read port, walking
// from the word of bit_index to the word of range_end, at most all words of
// a full 16384-bit key. A new command is taken as soon as the sequencer is
// idle and the output register is empty or being emptied in the same cycle.
// Stored words are not cleared at reset; reading a word that was never
// loaded returns whatever the memory holds. Writing key_length leaves the
// stored words as they are and should only happen while no command is in
// progress.
module key_bit_store_range_parity #(
	parameter int KEY_WORDS = kbsrp_pkg::KEY_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [kbsrp_pkg::LEN_W-1:0]   cfg_wdata,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  kbsrp_pkg::item_t              item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output kbsrp_pkg::result_t            result
);

	localparam int AW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_BIT  = 3'b010,
		S_PAR  = 3'b100
	} state_t;

	state_t state_q, state_d;

	logic [kbsrp_pkg::LEN_W-1:0] key_length_q;

	// Command context captured at transfer time.
	logic [2:0] cmd_q;
	logic [5:0] start_pos_q;
	logic [5:0] end_pos_q;
	logic [7:0] ws_q;
	logic [7:0] we_q;
	logic [7:0] cur_q;
	logic       new_bit_q;
	logic       par_q;

	// Output register.
	kbsrp_pkg::result_t res_q, res_d;
	logic               res_valid_q;
	logic               res_load;

	// Key memory ports.
	logic [63:0] key_mem [KEY_WORDS];
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [63:0]   rd_data_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]   wr_data;

	kbsrp_pkg::dec_t dec;
	logic            item_xfer;
	logic            cur_bit;
	logic [63:0]     par_word;
	logic            par_d;

	kbsrp_decode #(
		.KEY_WORDS(KEY_WORDS)
	) u_decode (
		.item       (item),
		.key_length (key_length_q),
		.dec        (dec)
	);

	// A command is taken only when the sequencer is idle and the output
	// register will be free at the next edge, so every command finds room
	// for its result when it completes.
	assign item_stall = (state_q != S_IDLE) || (res_valid_q && result_stall);
	assign item_xfer  = item_valid && !item_stall;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		cur_bit  = rd_data_q[start_pos_q];
		par_word = rd_data_q
			& ((cur_q == ws_q) ? kbsrp_pkg::low_mask(start_pos_q) : kbsrp_pkg::ALL_ONES)
			& ((cur_q == we_q) ? kbsrp_pkg::high_mask(end_pos_q) : kbsrp_pkg::ALL_ONES);
		par_d    = par_q ^ (^par_word);
	end

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		res_d    = '0;
		rd_en    = 1'b0;
		rd_addr  = AW'(item.bit_index[13:6]);
		wr_en    = 1'b0;
		wr_addr  = AW'(item.word_index);
		wr_data  = dec.load_data;
		unique case (state_q)
			S_IDLE: begin
				if (item_xfer) begin
					if (dec.immediate) begin
						res_load     = 1'b1;
						res_d.status = dec.status;
						wr_en        = dec.load;
					end else begin
						// Fetch the word holding the bit, or the first word of the range.
						rd_en   = 1'b1;
						state_d = (item.command == kbsrp_pkg::CMD_PARITY) ? S_PAR : S_BIT;
					end
				end
			end
			S_BIT: begin
				// Read data now holds the addressed word: test it or write it back.
				wr_addr  = AW'(cur_q);
				wr_data  = rd_data_q;
				res_load = 1'b1;
				state_d  = S_IDLE;
				case (cmd_q)
					kbsrp_pkg::CMD_READ: begin
						res_d.bit_out = cur_bit;
					end
					kbsrp_pkg::CMD_SET: begin
						wr_en                = 1'b1;
						wr_data[start_pos_q] = new_bit_q;
					end
					default: begin
						wr_en                = 1'b1;
						wr_data[start_pos_q] = ~cur_bit;
					end
				endcase
			end
			S_PAR: begin
				// One word of the range arrives per cycle; the next read is
				// issued while the current word is folded into the parity.
				if (cur_q == we_q) begin
					res_load         = 1'b1;
					res_d.parity_out = par_d;
					state_d          = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(cur_q + 8'd1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			key_length_q <= kbsrp_pkg::KEY_LENGTH_RST;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				key_length_q <= cfg_wdata;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
		if (item_xfer) begin
			cmd_q       <= item.command;
			start_pos_q <= item.bit_index[5:0];
			end_pos_q   <= item.range_end[5:0];
			ws_q        <= item.bit_index[13:6];
			cur_q       <= item.bit_index[13:6];
			we_q        <= item.range_end[13:6];
			new_bit_q   <= item.new_bit;
			par_q       <= 1'b0;
		end else if (state_q == S_PAR && cur_q != we_q) begin
			cur_q <= cur_q + 8'd1;
			par_q <= par_d;
		end
	end

	// Key memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= key_mem[rd_addr];
		end
	end

endmodule

// File: rtl/kbsrp_decode.sv
// ----------------------------------------------------------------------------
// kbsrp_decode: command decode and bounds checks
// Saturates the key length to the store size, checks indexes and ranges,
// and builds the masked word for a load.
// ----------------------------------------------------------------------------
module kbsrp_decode #(
	parameter int KEY_WORDS = kbsrp_pkg::KEY_WORDS_DEF
) (
	input  kbsrp_pkg::item_t                  item,
	input  logic [kbsrp_pkg::LEN_W-1:0]       key_length,
	output kbsrp_pkg::dec_t                   dec
);

	localparam int CAP = KEY_WORDS * kbsrp_pkg::WORD_BITS;

	logic [kbsrp_pkg::LEN_W-1:0] eff_len;
	logic [kbsrp_pkg::LEN_W-1:0] start_x;
	logic [kbsrp_pkg::LEN_W-1:0] end_x;
	logic [kbsrp_pkg::LEN_W-1:0] base;
	logic [kbsrp_pkg::LEN_W-1:0] remain;
	logic [63:0]                 lmask;

	always_comb begin
		eff_len = (32'(key_length) > CAP) ? kbsrp_pkg::LEN_W'(CAP) : key_length;
		start_x = {1'b0, item.bit_index};
		end_x   = {1'b0, item.range_end};
		base    = {1'b0, item.word_index, 6'd0};
		remain  = eff_len - base;
		lmask   = (remain < 15'd64) ? ~(kbsrp_pkg::ALL_ONES << remain[5:0])
		                            : kbsrp_pkg::ALL_ONES;
	end

	always_comb begin
		dec.immediate = 1'b1;
		dec.load      = 1'b0;
		dec.status    = kbsrp_pkg::ST_OK;
		dec.load_data = item.word_data & lmask;
		unique case (item.command) inside
			kbsrp_pkg::CMD_LOAD: begin
				if (base >= eff_len) begin
					dec.status = kbsrp_pkg::ST_RANGE;
				end else begin
					dec.load = 1'b1;
				end
			end
			kbsrp_pkg::CMD_READ, kbsrp_pkg::CMD_SET, kbsrp_pkg::CMD_FLIP: begin
				if (start_x >= eff_len) begin
					dec.status = kbsrp_pkg::ST_RANGE;
				end else begin
					dec.immediate = 1'b0;
				end
			end
			kbsrp_pkg::CMD_PARITY: begin
				if (start_x >= eff_len || end_x >= eff_len) begin
					dec.status = kbsrp_pkg::ST_RANGE;
				end else if (end_x < start_x) begin
					dec.status = kbsrp_pkg::ST_REVERSED;
				end else begin
					dec.immediate = 1'b0;
				end
			end
			default: begin
				dec.immediate = 1'b1;
			end
		endcase
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key bit store regression bench
// Sends load, read, set, flip, range parity and unknown commands to the key
// bit store under several key lengths and handshake idling patterns. It checks
// every result against a behavioral copy of the store kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 4;
	localparam int KEY_CAP        = kbsrp_pkg::KEY_WORDS_DEF * kbsrp_pkg::WORD_BITS;
	// The longest parity walk covers every word once, and END_SETTLE quiet
	// cycles at the end give any stray result time to show up.
	localparam int END_SETTLE     = 300;
	localparam int CFG_SETTLE     = 4;
	// Cycles with no transfer on either channel before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 5000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_wen = 1'b0;
	logic [kbsrp_pkg::LEN_W-1:0]   cfg_wdata = '0;
	logic                          item_valid = 1'b0;
	logic                          item_stall;
	kbsrp_pkg::item_t              item = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	kbsrp_pkg::result_t            result;

	// Bench copy of the store and of the key length register.
	logic [63:0]                   key_mem [kbsrp_pkg::KEY_WORDS_DEF];
	logic [kbsrp_pkg::LEN_W-1:0]   key_len_q = kbsrp_pkg::KEY_LENGTH_RST;

	// Results still owed by the block, oldest first.
	kbsrp_pkg::result_t            key_answers_q [$];

	int unsigned        sender_idle_pct = 0;
	int unsigned        receiver_stall_pct = 0;
	int unsigned        quiet_cycles = 0;
	int unsigned        mismatch_count = 0;
	int unsigned        command_count [8];
	int unsigned        status_count [4];

	key_bit_store_range_parity #(
		.KEY_WORDS(kbsrp_pkg::KEY_WORDS_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// Behavioral store.
	// ------------------------------------------------------------------------

	// Key length as the block sees it: the register saturated to the store size.
	function automatic int unsigned eff_length();
		return (key_len_q > KEY_CAP) ? KEY_CAP : key_len_q;
	endfunction

	// Applies one command to the bench copy of the store and returns the
	// result that the block must produce for it.
	function automatic kbsrp_pkg::result_t apply_key_command(input kbsrp_pkg::item_t cmd);
		kbsrp_pkg::result_t r;
		int unsigned len;
		int unsigned base;
		int unsigned first_word;
		int unsigned last_word;
		logic [63:0] mask;
		logic [63:0] word;
		logic [63:0] acc;
		r = '0;
		len = eff_length();
		case (cmd.command) inside
			kbsrp_pkg::CMD_LOAD: begin
				base = cmd.word_index * kbsrp_pkg::WORD_BITS;
				if (base >= len) begin
					r.status = kbsrp_pkg::ST_RANGE;
				end else begin
					// A word that straddles the end of the key keeps only its valid bits.
					mask = kbsrp_pkg::ALL_ONES;
					if (len - base < kbsrp_pkg::WORD_BITS)
						mask = (64'd1 << (len - base)) - 64'd1;
					key_mem[cmd.word_index] = cmd.word_data & mask;
				end
			end
			kbsrp_pkg::CMD_READ, kbsrp_pkg::CMD_SET, kbsrp_pkg::CMD_FLIP: begin
				if (cmd.bit_index >= len) begin
					r.status = kbsrp_pkg::ST_RANGE;
				end else if (cmd.command == kbsrp_pkg::CMD_READ) begin
					r.bit_out = key_mem[cmd.bit_index[13:6]][cmd.bit_index[5:0]];
				end else if (cmd.command == kbsrp_pkg::CMD_SET) begin
					key_mem[cmd.bit_index[13:6]][cmd.bit_index[5:0]] = cmd.new_bit;
				end else begin
					key_mem[cmd.bit_index[13:6]][cmd.bit_index[5:0]] =
						~key_mem[cmd.bit_index[13:6]][cmd.bit_index[5:0]];
				end
			end
			kbsrp_pkg::CMD_PARITY: begin
				// The length check wins over the reversed range check.
				if (cmd.bit_index >= len || cmd.range_end >= len) begin
					r.status = kbsrp_pkg::ST_RANGE;
				end else if (cmd.range_end < cmd.bit_index) begin
					r.status = kbsrp_pkg::ST_REVERSED;
				end else begin
					first_word = cmd.bit_index[13:6];
					last_word = cmd.range_end[13:6];
					acc = '0;
					for (int unsigned w = first_word; w <= last_word; w++) begin
						word = key_mem[w];
						if (w == first_word)
							word &= kbsrp_pkg::ALL_ONES << cmd.bit_index[5:0];
						if (w == last_word)
							word &= kbsrp_pkg::ALL_ONES >> (63 - cmd.range_end[5:0]);
						acc ^= word;
					end
					r.parity_out = ^acc;
				end
			end
			default: begin
				// Unknown commands leave the store alone and answer all zero.
			end
		endcase
		return r;
	endfunction

	function automatic kbsrp_pkg::item_t make_cmd(input logic [2:0] command,
			input int unsigned bit_idx, input int unsigned last_bit, input logic nbit,
			input int unsigned widx, input logic [63:0] data);
		kbsrp_pkg::item_t c;
		c.command = command;
		c.bit_index = bit_idx[13:0];
		c.range_end = last_bit[13:0];
		c.new_bit = nbit;
		c.word_index = widx[7:0];
		c.word_data = data;
		return c;
	endfunction

	// Builds one random command shaped by the current key length. Most indexes
	// land inside the key so that the store is really exercised; one in ten
	// uses the whole field range and so hits the length check.
	function automatic kbsrp_pkg::item_t random_command();
		kbsrp_pkg::item_t c;
		int unsigned len;
		int unsigned pick;
		int unsigned last_bit;
		len = eff_length();
		c.command = 3'($urandom_range(0, 7));
		c.bit_index = 14'($urandom);
		c.range_end = 14'($urandom);
		c.new_bit = 1'($urandom);
		c.word_index = 8'($urandom);
		c.word_data = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 15)
			c.command = kbsrp_pkg::CMD_LOAD;
		else if (pick < 35)
			c.command = kbsrp_pkg::CMD_READ;
		else if (pick < 50)
			c.command = kbsrp_pkg::CMD_SET;
		else if (pick < 65)
			c.command = kbsrp_pkg::CMD_FLIP;
		else if (pick < 95)
			c.command = kbsrp_pkg::CMD_PARITY;
		else
			c.command = 3'($urandom_range(5, 7));
		if (len > 0 && $urandom_range(0, 9) != 0) begin
			c.bit_index = 14'($urandom_range(0, len - 1));
			c.word_index = 8'($urandom_range(0, (len - 1) / kbsrp_pkg::WORD_BITS));
			pick = $urandom_range(0, 99);
			// Short ranges dominate so the word walk stays cheap; a few run on to
			// a random point up to the key's end, some are reversed, and some end anywhere.
			if (pick < 70)
				last_bit = c.bit_index + $urandom_range(0, 200);
			else if (pick < 88)
				last_bit = c.bit_index + $urandom_range(0, 1500);
			else if (pick < 94)
				last_bit = $urandom_range(c.bit_index, len - 1);
			else if (pick < 97 && c.bit_index > 0)
				last_bit = $urandom_range(0, c.bit_index - 1);
			else
				last_bit = $urandom_range(0, 16383);
			if (pick < 88 && last_bit >= len)
				last_bit = len - 1;
			c.range_end = last_bit[13:0];
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Handshake helpers.
	// ------------------------------------------------------------------------

	// Presents one command and holds it until the block takes it. The idle
	// decision is made before valid goes up, so valid never follows stall.
	task automatic issue_command(input kbsrp_pkg::item_t cmd);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= cmd;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		command_count[cmd.command]++;
		key_answers_q.push_back(apply_key_command(cmd));
	endtask

	// Drops valid and waits until every owed result has come back, then
	// settle more cycles for anything unexpected to surface.
	task automatic drain_results(input int unsigned settle);
		@(negedge clk);
		item_valid <= 1'b0;
		while (key_answers_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// The length register is only written with the block idle.
	task automatic set_key_length(input int unsigned len);
		drain_results(CFG_SETTLE);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= len[kbsrp_pkg::LEN_W-1:0];
		@(negedge clk);
		cfg_wen <= 1'b0;
		key_len_q = len[kbsrp_pkg::LEN_W-1:0];
	endtask

	task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
		sender_idle_pct = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// Every command at the default length, touching only words loaded here:
	// the lowest and highest bits of the key, a single bit range, a range that
	// crosses a word edge, a reversed range and the unknown command codes.
	task automatic test_basic_commands();
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 0, kbsrp_pkg::ALL_ONES));
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 255,
			64'h8000_0000_0000_0001));
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 1, {$urandom, $urandom}));
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 0, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 16383, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_SET, 1, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_SET, 64, 0, 1'b1, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_FLIP, 0, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 0, 63, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 0, 127, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 5, 5, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 63, 64, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 10, 9, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 16320, 0, 1'b0, 0, '0));
		for (int c = 5; c <= 7; c++)
			issue_command(make_cmd(3'(c), 16383, 16383, 1'b1, 255, kbsrp_pkg::ALL_ONES));
	endtask

	// Loads every word so that no later command reads an unwritten word.
	task automatic test_fill_store();
		for (int unsigned w = 0; w < kbsrp_pkg::KEY_WORDS_DEF; w++)
			issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, w,
				{$urandom, $urandom}));
	endtask

	// Length edges: a length that ends inside a word, growing the length back
	// over masked and kept bits, zero length, a register value above the store
	// size, and a one-bit key.
	task automatic test_key_length();
		set_key_length(100);
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 1, kbsrp_pkg::ALL_ONES));
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 99, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 100, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_FLIP, 99, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 64, 99, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 99, 100, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 2, kbsrp_pkg::ALL_ONES));
		issue_command(make_cmd(kbsrp_pkg::CMD_SET, 16383, 0, 1'b1, 0, '0));
		set_key_length(KEY_CAP);
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 100, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 0, 16383, 1'b0, 0, '0));
		set_key_length(0);
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 0, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 0, kbsrp_pkg::ALL_ONES));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 0, 0, 1'b0, 0, '0));
		set_key_length(32767);
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 16383, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_PARITY, 16320, 16383, 1'b0, 0, '0));
		set_key_length(1);
		issue_command(make_cmd(kbsrp_pkg::CMD_LOAD, 0, 0, 1'b0, 0, {$urandom, $urandom}));
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 0, 0, 1'b0, 0, '0));
		issue_command(make_cmd(kbsrp_pkg::CMD_READ, 1, 0, 1'b0, 0, '0));
	endtask

	task automatic test_random_traffic(input int unsigned len, input int unsigned sender_pct,
			input int unsigned receiver_pct, input int unsigned count);
		set_key_length(len);
		set_idling(sender_pct, receiver_pct);
		repeat (count) issue_command(random_command());
	endtask

	// ------------------------------------------------------------------------
	// Receiver side: random stall, result checking and the watchdog.
	// ------------------------------------------------------------------------

	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

	always @(posedge clk) begin
		kbsrp_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (key_answers_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: result transfer with none outstanding: bit %b parity %b status %0d",
					$time, result.bit_out, result.parity_out, result.status);
			end else begin
				want = key_answers_q.pop_front();
				status_count[want.status]++;
				if (result.bit_out !== want.bit_out) begin
					mismatch_count++;
					$display("%0t: bit_out expected %b actual %b", $time, want.bit_out,
						result.bit_out);
				end
				if (result.parity_out !== want.parity_out) begin
					mismatch_count++;
					$display("%0t: parity_out expected %b actual %b", $time, want.parity_out,
						result.parity_out);
				end
				if (result.status !== want.status) begin
					mismatch_count++;
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						result.status);
				end
			end
		end
	end

	// A hang shows up as a long stretch with no transfer on either channel.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
				quiet_cycles, key_answers_q.size());
			$display("key_bit_store_range_parity regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------

	initial begin
		foreach (command_count[i])
			command_count[i] = 0;
		foreach (status_count[i])
			status_count[i] = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		set_idling(0, 0);
		test_basic_commands();
		test_fill_store();
		test_key_length();

		// Random traffic under each idling pattern, two key lengths apiece.
		test_random_traffic(KEY_CAP, 0, 0, 220);
		test_random_traffic($urandom_range(1, KEY_CAP), 0, 0, 220);
		test_random_traffic(32767, 87, 0, 220);
		test_random_traffic(1, 87, 0, 40);
		test_random_traffic($urandom_range(1, KEY_CAP), 0, 87, 220);
		test_random_traffic(64, 0, 87, 220);
		test_random_traffic($urandom_range(1, KEY_CAP), 25, 25, 220);
		test_random_traffic(0, 25, 25, 40);

		drain_results(END_SETTLE);
		$display("Covered %0d loads, %0d reads, %0d sets, %0d flips, %0d range parities, %0d unknown.",
			command_count[kbsrp_pkg::CMD_LOAD], command_count[kbsrp_pkg::CMD_READ],
			command_count[kbsrp_pkg::CMD_SET], command_count[kbsrp_pkg::CMD_FLIP],
			command_count[kbsrp_pkg::CMD_PARITY],
			command_count[5] + command_count[6] + command_count[7]);
		$display("Results: %0d ok, %0d beyond key length, %0d reversed range, %0d mismatches.",
			status_count[kbsrp_pkg::ST_OK], status_count[kbsrp_pkg::ST_RANGE],
			status_count[kbsrp_pkg::ST_REVERSED], mismatch_count);
		if (mismatch_count == 0 && key_answers_q.size() == 0)
			$display("key_bit_store_range_parity regression: pass");
		else
			$display("key_bit_store_range_parity regression: fail");
		$finish;
	end

endmodule

// File: key_bit_store_range_parity.f
rtl/kbsrp_pkg.sv
rtl/kbsrp_decode.sv
rtl/key_bit_store_range_parity.sv
bench/testbench.sv
